### hw/rtl/ovrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovrb_pkg
// Shared types and fixed field widths of the overwriting record ring buffer.
// ----------------------------------------------------------------------------
package ovrb_pkg;

  localparam int CFG_W    = 13;  // buffer_bytes register
  localparam int RLEN_W   = 12;  // record_length
  localparam int ROFF_W   = 12;  // read_offset
  localparam int RCNT_W   = 7;   // read_length
  localparam int IN_DW    = 40;  // s_axis_tdata
  localparam int IN_UW    = 3;   // s_axis_tuser
  localparam int OUT_DW   = 16;  // m_axis_tdata

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WSTART,
    S_DISC_CHK,
    S_HDR,
    S_DISC_UPD,
    S_PLACE,
    S_ACK,
    S_RD_CHK,
    S_RD_UPD,
    S_RD_ADV,
    S_RD_ISS,
    S_RD_GOT,
    S_RD_FIN
  } state_e;

endpackage

### hw/rtl/ovrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovrb_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ovrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/overwriting_record_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_record_ring_buffer
// Byte ring of length-prefixed records that overwrites its oldest records.
// ----------------------------------------------------------------------------
// Records live in one byte RAM as a HDR_BYTES little-endian header (header
// size plus payload length), the payload, and a zero end marker. A payload
// byte that follows a record start is written in the cycle it is accepted,
// so a record streams at one byte per cycle. A record start walks and
// discards the header of every old record that its window overlaps, one
// header byte per cycle through the single RAM read port. A read request
// walks the record headers the same way, then reads each returned byte in
// turn. The input is held off while a record start, a read or an
// acknowledge is in progress; a result waiting in the output register does
// not stall payload bytes. There is no clearing pass after reset: a clear
// or a register write empties the ring.
module overwriting_record_ring_buffer #(
  parameter int BUF_BYTES = 4096,
  parameter int HDR_BYTES = 4,
  parameter int MAX_READ  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ovrb_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] data_byte, [19:8] record_length, [31:20] read_offset,
  // [38:32] read_length, [39] zero
  input  logic [ovrb_pkg::IN_DW-1:0]  s_axis_tdata,
  // [1:0] req_type, [2] first_byte
  input  logic [ovrb_pkg::IN_UW-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] accepted, [1] valid_data, [9:2] read_byte, [15:10] zero
  output logic [ovrb_pkg::OUT_DW-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);
  import ovrb_pkg::*;

  localparam int AW  = $clog2(BUF_BYTES);
  localparam int SW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int HW  = 8 * HDR_BYTES;
  localparam int XW  = ((HW > SW) ? HW : SW) + 1;
  localparam int HCW = $clog2(HDR_BYTES + 1);
  localparam int PCW = $clog2(2 * HDR_BYTES + 1);
  localparam int WALK_LIMIT = 2 * BUF_BYTES + 4;
  localparam int NW  = $clog2(WALK_LIMIT + 1);
  localparam logic [XW-1:0] HDR_X  = XW'(HDR_BYTES);
  localparam logic [XW-1:0] HMAX_X = XW'((64'd1 << HW) - 64'd1);

  // input fields
  req_e              req_type;
  logic              first_byte;
  logic [7:0]        data_byte;
  logic [RLEN_W-1:0] record_length;
  logic [ROFF_W-1:0] read_offset;
  logic [RCNT_W-1:0] read_length;
  logic              s_fire;

  assign req_type      = req_e'(s_axis_tuser[1:0]);
  assign first_byte    = s_axis_tuser[2];
  assign data_byte     = s_axis_tdata[7:0];
  assign record_length = s_axis_tdata[19:8];
  assign read_offset   = s_axis_tdata[31:20];
  assign read_length   = s_axis_tdata[38:32];
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d, ret_q, ret_d;

  logic [CFG_W-1:0]  ring_bytes_q, ring_bytes_d;
  logic [AW-1:0]     rp_q, rp_d, wp_q, wp_d, cur_q, cur_d;
  logic [SW-1:0]     sp_q, sp_d;
  logic              drop_q, drop_d;

  logic [RLEN_W-1:0] size_q, size_d;
  logic [7:0]        byte_q, byte_d;
  logic [AW-1:0]     w_q, w_d, wploc_q, wploc_d;
  logic [SW-1:0]     len_q, len_d;
  logic              phase_q, phase_d;
  logic [NW-1:0]     n_q, n_d;
  logic [AW-1:0]     hbase_q, hbase_d;
  logic [HCW-1:0]    hcnt_q, hcnt_d;
  logic [HW-1:0]     hdr_q, hdr_d;
  logic              inr_q, inr_d;
  logic [PCW-1:0]    pcnt_q, pcnt_d;
  logic              acc_q, acc_d;

  logic [ROFF_W-1:0] off_q, off_d;
  logic [RCNT_W-1:0] rem_q, rem_d, ccnt_q, ccnt_d;
  logic [SW-1:0]     asz_q, asz_d;
  logic [AW-1:0]     p_q, p_d;
  logic [XW-1:0]     caddr_q, caddr_d;
  logic [7:0]        pend_q, pend_d;
  logic              pend_v_q, pend_v_d;

  logic              m_valid_q;
  logic [OUT_DW-1:0] m_data_q;
  logic              m_user_q, m_last_q;
  logic              out_free, out_load, out_kind, out_acc, out_vld, out_last;
  logic [7:0]        out_byte;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // scratch values of the combinational block
  logic [XW-1:0] a_x, esize_x, wspace_x, hb_x, esz_x, sum_x, sat_x, c_x;
  logic [XW-1:0] hv_x, newwp_x, wa_x;
  logic [RCNT_W-1:0] cmin;
  logic [7:0]        gb;

  assign a_x = (XW'(ring_bytes_q) > XW'(BUF_BYTES)) ? XW'(BUF_BYTES) : XW'(ring_bytes_q);
  assign out_free = !m_valid_q || m_axis_tready;

  ovrb_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    ring_bytes_d = ring_bytes_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    cur_d        = cur_q;
    sp_d         = sp_q;
    drop_d       = drop_q;
    size_d       = size_q;
    byte_d       = byte_q;
    w_d          = w_q;
    wploc_d      = wploc_q;
    len_d        = len_q;
    phase_d      = phase_q;
    n_d          = n_q;
    hbase_d      = hbase_q;
    hcnt_d       = hcnt_q;
    hdr_d        = hdr_q;
    inr_d        = inr_q;
    pcnt_d       = pcnt_q;
    acc_d        = acc_q;
    off_d        = off_q;
    rem_d        = rem_q;
    ccnt_d       = ccnt_q;
    asz_d        = asz_q;
    p_d          = p_q;
    caddr_d      = caddr_q;
    pend_d       = pend_q;
    pend_v_d     = pend_v_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    out_load     = 1'b0;
    out_kind     = 1'b0;
    out_acc      = 1'b0;
    out_vld      = 1'b0;
    out_byte     = '0;
    out_last     = 1'b0;
    s_axis_tready = 1'b0;
    esize_x  = XW'(size_q) + XW'(2 * HDR_BYTES);
    wspace_x = (a_x > XW'(wp_q)) ? a_x - XW'(wp_q) : '0;
    hb_x     = XW'(hbase_q) + XW'(hcnt_q);
    esz_x    = XW'(hdr_q) - HDR_X;
    sum_x    = '0;
    sat_x    = '0;
    c_x      = '0;
    cmin     = '0;
    gb       = inr_q ? ram_rdata : 8'd0;
    hv_x     = XW'(size_q) + HDR_X;
    newwp_x  = XW'(wploc_q) + hv_x;
    wa_x     = '0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_fire) begin
          case (req_type)
            REQ_WRITE: begin
              if (first_byte) begin
                size_d  = record_length;
                byte_d  = data_byte;
                state_d = S_WSTART;
              end else if (!drop_q && cur_q < wp_q) begin
                ram_we    = XW'(cur_q) < a_x;
                ram_waddr = cur_q;
                ram_wdata = data_byte;
                cur_d     = cur_q + AW'(1);
              end
            end
            REQ_READ: begin
              off_d    = read_offset;
              rem_d    = (read_length > RCNT_W'(MAX_READ)) ? RCNT_W'(MAX_READ) : read_length;
              asz_d    = sp_q;
              p_d      = rp_q;
              n_d      = '0;
              pend_v_d = 1'b0;
              state_d  = S_RD_CHK;
            end
            REQ_CLEAR: begin
              rp_d   = '0;
              wp_d   = '0;
              sp_d   = '0;
              cur_d  = '0;
              drop_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_WSTART: begin
        if (esize_x > a_x || hv_x > HMAX_X) begin
          drop_d  = 1'b1;
          cur_d   = wp_q;
          acc_d   = 1'b0;
          state_d = S_ACK;
        end else begin
          n_d     = '0;
          w_d     = wp_q;
          wploc_d = wp_q;
          if (esize_x > wspace_x) begin
            len_d   = SW'(wspace_x);
            phase_d = 1'b0;
          end else begin
            len_d   = SW'(esize_x);
            phase_d = 1'b1;
          end
          state_d = S_DISC_CHK;
        end
      end

      // discard oldest records while the read pointer lies in the window
      S_DISC_CHK: begin
        if (sp_q != '0 && XW'(rp_q) >= XW'(w_q) && XW'(rp_q) < XW'(w_q) + XW'(len_q) &&
            n_q < NW'(WALK_LIMIT)) begin
          n_d     = n_q + NW'(1);
          hbase_d = rp_q;
          hcnt_d  = '0;
          ret_d   = S_DISC_UPD;
          state_d = S_HDR;
        end else if (!phase_q) begin
          // record wraps: second window starts at offset zero
          phase_d = 1'b1;
          wploc_d = '0;
          w_d     = '0;
          len_d   = SW'(esize_x);
          n_d     = '0;
        end else begin
          pcnt_d  = '0;
          state_d = S_PLACE;
        end
      end

      // header fetch, one byte per cycle, data arrives in the next cycle from the registered RAM read
      S_HDR: begin
        if (int'(hcnt_q) < HDR_BYTES) begin
          ram_raddr = hb_x[AW-1:0];
        end
        inr_d = hb_x < a_x;
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (i + 1 == int'(hcnt_q)) begin
            hdr_d[8*i +: 8] = gb;
          end
        end
        hcnt_d = hcnt_q + HCW'(1);
        if (int'(hcnt_q) == HDR_BYTES) begin
          state_d = ret_q;
        end
      end

      S_DISC_UPD: begin
        if (XW'(hdr_q) >= HDR_X) begin
          sum_x = XW'(rp_q) + XW'(hdr_q);
          sat_x = (XW'(sp_q) > esz_x) ? XW'(sp_q) - esz_x : '0;
          sp_d  = SW'(sat_x);
          if (sat_x == '0 || sum_x >= a_x) begin
            rp_d = '0;
          end else begin
            rp_d = sum_x[AW-1:0];
          end
        end else begin
          rp_d = '0;
        end
        state_d = S_DISC_CHK;
      end

      // header bytes, then end marker, then first payload byte
      S_PLACE: begin
        if (int'(pcnt_q) < HDR_BYTES) begin
          wa_x = XW'(wploc_q) + XW'(pcnt_q);
          for (int i = 0; i < HDR_BYTES; i++) begin
            if (i == int'(pcnt_q)) begin
              ram_wdata = hv_x[8*i +: 8];
            end
          end
          ram_we = wa_x < a_x;
        end else if (int'(pcnt_q) < 2 * HDR_BYTES) begin
          wa_x   = newwp_x + XW'(pcnt_q) - HDR_X;
          ram_we = wa_x < a_x;
        end else begin
          wa_x      = XW'(wploc_q) + HDR_X;
          ram_wdata = byte_q;
          ram_we    = (size_q != '0) && (wa_x < a_x);
        end
        ram_waddr = wa_x[AW-1:0];
        pcnt_d    = pcnt_q + PCW'(1);
        if (int'(pcnt_q) == 2 * HDR_BYTES) begin
          wp_d    = newwp_x[AW-1:0];
          cur_d   = AW'(XW'(wploc_q) + HDR_X + XW'(size_q != '0));
          sp_d    = SW'(XW'(sp_q) + XW'(size_q));
          drop_d  = 1'b0;
          acc_d   = 1'b1;
          state_d = S_ACK;
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          out_acc  = acc_q;
          out_last = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_RD_CHK: begin
        if (asz_q != '0 && rem_q != '0 && n_q < NW'(WALK_LIMIT)) begin
          n_d     = n_q + NW'(1);
          hbase_d = p_q;
          hcnt_d  = '0;
          ret_d   = S_RD_UPD;
          state_d = S_HDR;
        end else begin
          state_d = S_RD_FIN;
        end
      end

      S_RD_UPD: begin
        if (XW'(hdr_q) >= HDR_X) begin
          if (XW'(off_q) >= esz_x) begin
            off_d   = ROFF_W'(XW'(off_q) - esz_x);
            state_d = S_RD_ADV;
          end else begin
            c_x     = esz_x - XW'(off_q);
            cmin    = (c_x > XW'(rem_q)) ? rem_q : c_x[RCNT_W-1:0];
            ccnt_d  = cmin;
            rem_d   = rem_q - cmin;
            caddr_d = XW'(p_q) + HDR_X + XW'(off_q);
            off_d   = '0;
            state_d = S_RD_ISS;
          end
        end else begin
          p_d     = '0;
          state_d = S_RD_CHK;
        end
      end

      S_RD_ADV: begin
        sum_x   = XW'(p_q) + XW'(hdr_q);
        p_d     = (sum_x >= a_x) ? '0 : sum_x[AW-1:0];
        sat_x   = (XW'(asz_q) > esz_x) ? XW'(asz_q) - esz_x : '0;
        asz_d   = SW'(sat_x);
        state_d = S_RD_CHK;
      end

      S_RD_ISS: begin
        ram_raddr = caddr_q[AW-1:0];
        inr_d     = caddr_q < a_x;
        state_d   = S_RD_GOT;
      end

      // one byte is held back so that the final one can carry tlast
      S_RD_GOT: begin
        ram_raddr = caddr_q[AW-1:0];
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_load = 1'b1;
            out_kind = 1'b1;
            out_vld  = 1'b1;
            out_byte = pend_q;
          end
          pend_d   = gb;
          pend_v_d = 1'b1;
          caddr_d  = caddr_q + XW'(1);
          ccnt_d   = ccnt_q - RCNT_W'(1);
          state_d  = (ccnt_q == RCNT_W'(1)) ? S_RD_ADV : S_RD_ISS;
        end
      end

      S_RD_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = 1'b1;
          out_vld  = pend_v_q;
          out_byte = pend_v_q ? pend_q : 8'd0;
          out_last = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      ring_bytes_d = cfg_wdata_i;
      rp_d         = '0;
      wp_d         = '0;
      sp_d         = '0;
      cur_d        = '0;
      drop_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_bytes_q <= CFG_W'(4096);
      rp_q         <= '0;
      wp_q         <= '0;
      cur_q        <= '0;
      sp_q         <= '0;
      drop_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      ring_bytes_q <= ring_bytes_d;
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      cur_q        <= cur_d;
      sp_q         <= sp_d;
      drop_q       <= drop_d;
      pend_v_q     <= pend_v_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    size_q  <= size_d;
    byte_q  <= byte_d;
    w_q     <= w_d;
    wploc_q <= wploc_d;
    len_q   <= len_d;
    phase_q <= phase_d;
    n_q     <= n_d;
    hbase_q <= hbase_d;
    hcnt_q  <= hcnt_d;
    hdr_q   <= hdr_d;
    inr_q   <= inr_d;
    pcnt_q  <= pcnt_d;
    acc_q   <= acc_d;
    off_q   <= off_d;
    rem_q   <= rem_d;
    ccnt_q  <= ccnt_d;
    asz_q   <= asz_d;
    p_q     <= p_d;
    caddr_q <= caddr_d;
    pend_q  <= pend_d;
    if (out_load) begin
      m_data_q <= {6'd0, out_byte, out_vld, out_acc};
      m_user_q <= out_kind;
      m_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule
